[src/csc_pkg.sv]
package csc_pkg;

    localparam int TICKS_PER_SECOND = 10;
    localparam int PHASE_W          = $clog2(TICKS_PER_SECOND);
    localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(TICKS_PER_SECOND - 1);

    localparam int HOURS_W   = 5;
    localparam int MINUTES_W = 7;
    localparam int SECONDS_W = 6;
    localparam int TENTHS_W  = 4;
    localparam int SEG_W     = 7;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 5;

    localparam logic [HOURS_W-1:0]   HOURS_PER_DAY   = 5'd24;
    localparam logic [HOURS_W-1:0]   START_HOUR_RST  = 5'd12;
    localparam logic [MINUTES_W-1:0] CLOCK_MIN_LIMIT = 7'd60;
    localparam logic [MINUTES_W-1:0] SW_MIN_LAST     = 7'd99;
    localparam logic [SECONDS_W-1:0] SEC_LIMIT       = 6'd60;
    localparam logic [TENTHS_W-1:0]  TENTHS_LIMIT    = 4'd10;
    localparam logic [SEG_W-1:0]     SEG_DASH        = 7'b0000001;

    localparam logic [MODE_W-1:0] MODE_IDLE      = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLOCK     = 2'd1;
    localparam logic [MODE_W-1:0] MODE_STOPWATCH = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNUSED    = 2'd3;

    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_RESTART = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_RUN_MODE   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_HOUR = 1'd1;

    typedef struct packed {
        logic req_type;
        logic hold;
    } in_data_t;

    typedef struct packed {
        logic                 display_update;
        logic [HOURS_W-1:0]   shown_hours;
        logic [MINUTES_W-1:0] shown_minutes;
        logic [SECONDS_W-1:0] shown_seconds;
        logic [TENTHS_W-1:0]  shown_tenths;
        logic [SEG_W-1:0]     segment_pattern;
        logic                 blink_led;
    } out_data_t;

    typedef struct packed {
        logic [MODE_W-1:0]  run_mode;
        logic [HOURS_W-1:0] start_hour;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_W-1:0]   phase;
        logic [HOURS_W-1:0]   hours;
        logic [MINUTES_W-1:0] minutes;
        logic [SECONDS_W-1:0] seconds;
        logic [TENTHS_W-1:0]  tenths;
        logic [SEG_W-1:0]     seg;
        logic                 led;
    } count_state_t;

    function automatic logic [SEG_W-1:0] seg_digit(input logic [3:0] d);
        logic [SEG_W-1:0] p;
        unique case (d)
            4'd0:    p = 7'b1111110;
            4'd1:    p = 7'b0110000;
            4'd2:    p = 7'b1101101;
            4'd3:    p = 7'b1111001;
            4'd4:    p = 7'b0110011;
            4'd5:    p = 7'b1011011;
            4'd6:    p = 7'b1011111;
            4'd7:    p = 7'b1110000;
            4'd8:    p = 7'b1111111;
            4'd9:    p = 7'b1111011;
            default: p = SEG_DASH;
        endcase
        return p;
    endfunction

endpackage

[src/csc_step.sv]
module csc_step (
    input  csc_pkg::count_state_t cur,
    input  csc_pkg::cfg_t         cfg,
    input  csc_pkg::in_data_t     req,
    output csc_pkg::count_state_t nxt,
    output csc_pkg::out_data_t    res
);
    import csc_pkg::*;

    logic [SECONDS_W:0]   c_sec_inc;
    logic                 c_sec_carry;
    logic [MINUTES_W:0]   c_min_sum;
    logic                 c_min_carry;
    logic [HOURS_W:0]     c_hour_sum;
    logic [TENTHS_W:0]    s_ten_inc;
    logic                 s_ten_carry;
    logic [SECONDS_W:0]   s_sec_sum;
    logic                 s_sec_carry;
    logic [MINUTES_W:0]   s_min_sum;
    logic                 phase_zero;

    always_comb
    begin
        c_sec_inc   = {1'b0, cur.seconds} + 1'b1;
        c_sec_carry = c_sec_inc >= {1'b0, SEC_LIMIT};
        c_min_sum   = {1'b0, cur.minutes} + {{MINUTES_W{1'b0}}, c_sec_carry};
        c_min_carry = c_min_sum >= {1'b0, CLOCK_MIN_LIMIT};
        c_hour_sum  = {1'b0, cur.hours} + {{HOURS_W{1'b0}}, c_min_carry};

        s_ten_inc   = {1'b0, cur.tenths} + 1'b1;
        s_ten_carry = s_ten_inc >= {1'b0, TENTHS_LIMIT};
        s_sec_sum   = {1'b0, cur.seconds} + {{SECONDS_W{1'b0}}, s_ten_carry};
        s_sec_carry = s_sec_sum >= {1'b0, SEC_LIMIT};
        s_min_sum   = {1'b0, cur.minutes} + {{MINUTES_W{1'b0}}, s_sec_carry};

        phase_zero  = cur.phase == '0;
    end

    always_comb
    begin
        nxt = cur;
        res = '0;
        if (req.req_type == REQ_RESTART)
        begin
            unique case (cfg.run_mode)
                MODE_CLOCK:
                begin
                    nxt.hours   = (cfg.start_hour < HOURS_PER_DAY) ? cfg.start_hour : '0;
                    nxt.minutes = '0;
                    nxt.seconds = '0;
                    nxt.phase   = '0;
                end
                MODE_STOPWATCH:
                begin
                    nxt.minutes = '0;
                    nxt.seconds = '0;
                    nxt.tenths  = '0;
                end
                default:
                begin
                end
            endcase
        end
        else
        begin
            unique case (cfg.run_mode)
                MODE_CLOCK:
                begin
                    if (!req.hold && phase_zero)
                    begin
                        res.display_update = 1'b1;
                        res.shown_hours    = cur.hours;
                        res.shown_minutes  = cur.minutes;
                        res.shown_seconds  = cur.seconds;
                        nxt.seg = (cur.seconds < SECONDS_W'(10)) ? seg_digit(cur.seconds[3:0])
                                                                 : SEG_DASH;
                        nxt.seconds = c_sec_carry ? '0 : c_sec_inc[SECONDS_W-1:0];
                        nxt.minutes = c_min_carry ? '0 : c_min_sum[MINUTES_W-1:0];
                        nxt.hours   = (c_hour_sum >= {1'b0, HOURS_PER_DAY}) ? '0
                                                                 : c_hour_sum[HOURS_W-1:0];
                    end
                end
                MODE_STOPWATCH:
                begin
                    if (!req.hold)
                    begin
                        if (phase_zero)
                        begin
                            nxt.led = ~cur.led;
                        end
                        res.display_update = 1'b1;
                        res.shown_minutes  = cur.minutes;
                        res.shown_seconds  = cur.seconds;
                        res.shown_tenths   = cur.tenths;
                        nxt.tenths  = s_ten_carry ? '0 : s_ten_inc[TENTHS_W-1:0];
                        nxt.seconds = s_sec_carry ? '0 : s_sec_sum[SECONDS_W-1:0];
                        nxt.minutes = (s_min_sum > {1'b0, SW_MIN_LAST}) ? '0
                                                               : s_min_sum[MINUTES_W-1:0];
                    end
                end
                default:
                begin
                end
            endcase
            nxt.phase = (cur.phase == PHASE_LAST) ? '0 : cur.phase + 1'b1;
        end
        res.segment_pattern = nxt.seg;
        res.blink_led       = nxt.led;
    end

endmodule

[src/clock_and_stopwatch_counter.sv]
// Time-of-day clock and stopwatch counter.
// Input channel (in_valid / in_stall / in_data): one transaction per tenth-second
// tick or per restart request. Output channel (out_valid / out_stall / out_data):
// exactly one result transaction per input transaction, in order.
// Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data): cfg_ready
// is always high; write only while no transaction is in flight.
// The result is registered and appears in out_data the cycle after the input is taken.
// Throughput: one transaction per cycle when not stalled; all counter updates
// happen in one combinational pass between the state and result registers.
// When the receiver stalls, the result register holds and in_stall follows
// out_stall while a result is pending, so nothing is lost.
// Reset: all counters, the phase, segment latch and LED clear to zero,
// run_mode goes idle and the restart hour goes to 12. No result is pending.
module clock_and_stopwatch_counter (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  csc_pkg::in_data_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output csc_pkg::out_data_t                  out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [csc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [csc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import csc_pkg::*;

    count_state_t state_reg;
    count_state_t state_next;
    cfg_t         cfg_reg;
    out_data_t    result_reg;
    out_data_t    result_next;
    logic         out_valid_reg;
    logic         accept;

    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = result_reg;

    csc_step u_step (
        .cur (state_reg),
        .cfg (cfg_reg),
        .req (in_data),
        .nxt (state_next),
        .res (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                state_reg     <= state_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg <= result_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.run_mode   <= MODE_IDLE;
            cfg_reg.start_hour <= START_HOUR_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_RUN_MODE:   cfg_reg.run_mode   <= cfg_data[MODE_W-1:0];
                CFG_START_HOUR: cfg_reg.start_hour <= cfg_data[HOURS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

endmodule

[src/csc_checker.sv]
module csc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    input  logic                                in_stall,
    input  csc_pkg::in_data_t                   in_data,
    input  logic                                out_valid,
    input  logic                                out_stall,
    input  csc_pkg::out_data_t                  out_data
);
    import csc_pkg::*;

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // every accepted input yields a result next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> out_valid)
        else $error("accepted input produced no result");

    a_no_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.display_update |->
            out_data.shown_hours == '0 && out_data.shown_minutes == '0 &&
            out_data.shown_seconds == '0 && out_data.shown_tenths == '0)
        else $error("shown time nonzero without report");

    // a report is either clock (no tenths) or stopwatch (no hours)
    a_report_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.display_update |->
            out_data.shown_tenths == '0 || out_data.shown_hours == '0)
        else $error("report mixes clock and stopwatch fields");

endmodule

bind clock_and_stopwatch_counter csc_checker u_csc_checker (.*);
